### sv/cdq_pkg.sv
package cdq_pkg;

    localparam int WORD_W    = 32;
    localparam int OCC_W     = 4;
    localparam int DEPTH_DEF = 8;

    // operation requested by an input beat
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } t_kind;

    // outcome reported with every result beat
    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_PUSH_F = 3'd1,
        CELL_PUSH_R = 3'd2,
        CELL_POP_F  = 3'd3,
        CELL_POP_R  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_kind                     kind;
        logic signed [WORD_W-1:0]  push_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0]  pop_value;
        t_status                   status;
        logic        [OCC_W-1:0]   occupancy;
    } t_out_beat;

    // what one cell shows its neighbours
    typedef struct packed {
        logic                      occ;
        logic signed [WORD_W-1:0]  data;
    } t_link;

endpackage

### sv/cdq_cell.sv
module cdq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cdq_pkg::t_cell_op                  i_op,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_word,
    input  cdq_pkg::t_link                     i_left,
    input  cdq_pkg::t_link                     i_right,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_tap,
    output cdq_pkg::t_link                     o_link,
    output logic signed [cdq_pkg::WORD_W-1:0]  o_tap
);

    logic                              r_occ;
    logic                              n_occ;
    logic signed [cdq_pkg::WORD_W-1:0] r_data;
    logic signed [cdq_pkg::WORD_W-1:0] n_data;
    logic signed [cdq_pkg::WORD_W-1:0] r_tap;
    logic signed [cdq_pkg::WORD_W-1:0] n_tap;

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        unique case (i_op)
            cdq_pkg::CELL_PUSH_F: begin
                n_occ  = i_left.occ;
                n_data = i_left.data;
            end
            cdq_pkg::CELL_PUSH_R: begin
                // first free cell takes the word
                n_occ = r_occ | i_left.occ;
                if (!r_occ && i_left.occ) begin
                    n_data = i_word;
                end
            end
            cdq_pkg::CELL_POP_F: begin
                n_occ  = i_right.occ;
                n_data = i_right.data;
            end
            cdq_pkg::CELL_POP_R: begin
                n_occ = i_right.occ;
            end
            default: begin
                n_occ  = r_occ;
                n_data = r_data;
            end
        endcase
    end

    // rear word travels one cell towards the front per cycle
    assign n_tap = (r_occ && !i_right.occ) ? r_data : i_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_link.occ  = r_occ;
    assign o_link.data = r_data;
    assign o_tap       = r_tap;

endmodule

### sv/cdq_ctrl.sv
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  cdq_pkg::t_in_beat                  i_cmd,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_front,
    input  logic signed [cdq_pkg::WORD_W-1:0]  i_rear,
    output logic                               o_busy,
    output cdq_pkg::t_cell_op                  o_op,
    output logic                               o_strobe,
    output cdq_pkg::t_out_beat                 o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           r_walk;
    logic [CW-1:0]           n_walk;
    logic                    r_strobe;
    logic                    n_strobe;
    cdq_pkg::t_out_beat      r_result;
    cdq_pkg::t_out_beat      n_result;
    logic                    full;
    logic                    empty;
    logic [CW+cdq_pkg::OCC_W-1:0] count_ext;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign count_ext = {{cdq_pkg::OCC_W{1'b0}}, n_count};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_walk   = r_walk;
        n_strobe = 1'b0;
        n_result = r_result;
        o_op     = cdq_pkg::CELL_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.kind)
                        cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_REAR: begin
                            n_strobe           = 1'b1;
                            n_result.pop_value = '0;
                            if (full) begin
                                n_result.status = cdq_pkg::STAT_FULL;
                            end else begin
                                n_result.status = cdq_pkg::STAT_DONE;
                                n_count         = r_count + CW'(1);
                                o_op = (i_cmd.kind == cdq_pkg::KIND_PUSH_FRONT)
                                     ? cdq_pkg::CELL_PUSH_F : cdq_pkg::CELL_PUSH_R;
                            end
                        end
                        cdq_pkg::KIND_POP_FRONT: begin
                            n_strobe = 1'b1;
                            if (empty) begin
                                n_result.status    = cdq_pkg::STAT_EMPTY;
                                n_result.pop_value = '1;
                            end else begin
                                n_result.status    = cdq_pkg::STAT_DONE;
                                n_result.pop_value = i_front;
                                n_count            = r_count - CW'(1);
                                o_op               = cdq_pkg::CELL_POP_F;
                            end
                        end
                        cdq_pkg::KIND_POP_REAR: begin
                            if (empty) begin
                                n_strobe           = 1'b1;
                                n_result.status    = cdq_pkg::STAT_EMPTY;
                                n_result.pop_value = '1;
                            end else begin
                                n_state = S_WALK;
                                n_walk  = r_count - CW'(1);
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_walk == '0) begin
                    // rear word has reached the front tap
                    n_strobe           = 1'b1;
                    n_result.status    = cdq_pkg::STAT_DONE;
                    n_result.pop_value = i_rear;
                    n_count            = r_count - CW'(1);
                    o_op               = cdq_pkg::CELL_POP_R;
                    n_state            = S_IDLE;
                end else begin
                    n_walk = r_walk - CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_result.occupancy = count_ext[cdq_pkg::OCC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_walk   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_walk   <= n_walk;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### sv/circular_deque.sv
// Channel   Ports                         Beat moves when
// -------   ---------------------------   -------------------------------
// command   start, busy, i_cmd            start high and busy low
// result    o_strobe, o_result            o_strobe high (one cycle only)
//
// Push and pop-front beats: result in the cycle after the command, next
// command may follow at once. Pop-rear: the rear word is carried to the
// front through the tap chain, one cell per cycle; busy stays high while
// it walks and the result follows once it reaches the front. Synchronous
// active-low reset empties the deque; word storage is not cleared. The
// receiver cannot stall; results are never held.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cdq_pkg::t_in_beat   i_cmd,
    output logic                o_strobe,
    output cdq_pkg::t_out_beat  o_result
);

    // Storage is a row of identical cells, front word always in cell 0,
    // stored words packed into cells 0..count-1. Each cell keeps an
    // occupied bit (together a thermometer of the count) so push-rear
    // and pop-rear decide locally from the neighbours' bits.

    cdq_pkg::t_cell_op                  cell_op;
    cdq_pkg::t_link                     cell_link [DEPTH];
    logic signed [cdq_pkg::WORD_W-1:0]  cell_tap  [DEPTH];
    cdq_pkg::t_link                     head_link;
    cdq_pkg::t_link                     end_link;

    // left of cell 0: the incoming word, always seen as occupied
    assign head_link.occ  = 1'b1;
    assign head_link.data = i_cmd.push_value;
    // right of the last cell: permanently empty
    assign end_link.occ   = 1'b0;
    assign end_link.data  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cdq_pkg::t_link                    left_l;
        cdq_pkg::t_link                    right_l;
        logic signed [cdq_pkg::WORD_W-1:0] right_tap;

        if (g == 0) begin : g_first
            assign left_l = head_link;
        end else begin : g_mid
            assign left_l = cell_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_l   = end_link;
            assign right_tap = '0;
        end else begin : g_inner
            assign right_l   = cell_link[g+1];
            assign right_tap = cell_tap[g+1];
        end

        cdq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (cell_op),
            .i_word  (i_cmd.push_value),
            .i_left  (left_l),
            .i_right (right_l),
            .i_tap   (right_tap),
            .o_link  (cell_link[g]),
            .o_tap   (cell_tap[g])
        );
    end

    // sequencer: decodes the beat, tracks the count, times the rear walk
    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_front  (cell_link[0].data),
        .i_rear   (cell_tap[0]),
        .o_busy   (busy),
        .o_op     (cell_op),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### sv/cdq_checker.sv
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  cdq_pkg::t_in_beat   i_cmd,
    input  logic                o_strobe,
    input  cdq_pkg::t_out_beat  o_result
);

    localparam logic [cdq_pkg::OCC_W-1:0] FULL_OCC = cdq_pkg::OCC_W'(DEPTH);

    // reset leaves the block quiet and ready
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy after reset");

    // everything but a pop-rear answers in the next cycle
    a_fast_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind != cdq_pkg::KIND_POP_REAR) |=> o_strobe)
        else $error("missing result beat");

    // refused pop: empty deque, word -1
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == cdq_pkg::STAT_EMPTY)
        |-> (o_result.pop_value == -32'sd1 && o_result.occupancy == '0))
        else $error("bad refused pop");

    // refused push: deque is full, word 0
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == cdq_pkg::STAT_FULL)
        |-> (o_result.pop_value == '0 && o_result.occupancy == FULL_OCC))
        else $error("bad refused push");

    // only legal status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status == cdq_pkg::STAT_DONE
                   || o_result.status == cdq_pkg::STAT_FULL
                   || o_result.status == cdq_pkg::STAT_EMPTY))
        else $error("illegal status");

endmodule

bind circular_deque cdq_checker #(
    .DEPTH (DEPTH)
) u_cdq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

### sim/circular_deque_tb.sv
`timescale 1ns / 100ps

// Command-style deque bench: a queue of command beats feeds a clocked driver,
// a clocked monitor predicts each accepted beat on a mirror of the deque and
// checks every strobed result against the oldest prediction.
module circular_deque_tb;

    import cdq_pkg::*;

    localparam int DQ_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no beat either way
    localparam int DRAIN_CYCLES = DQ_DEPTH + 4;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_in_beat   i_cmd   = '0;
    logic       o_strobe;
    t_out_beat  o_result;

    // command beats still to be offered; front is the one on the port
    t_in_beat   queued_cmds[$];
    // predicted results, oldest first
    t_out_beat  pending_results[$];

    // mirror of the deque contents and pointers
    logic signed [WORD_W-1:0] mirror_words [DQ_DEPTH];
    int mirror_head  = 0;
    int mirror_tail  = 0;
    int mirror_count = 0;

    int total_items  = 0;
    int cmds_taken   = 0;
    int results_seen = 0;
    int fail_count   = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;

    // coverage tallies for the closing summary
    int n_push = 0, n_pop = 0, n_pop_rear = 0, n_full = 0, n_empty = 0;

    circular_deque #(
        .DEPTH    (DQ_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic add_cmd(t_kind k, logic [WORD_W-1:0] v);
        t_in_beat b;
        b.kind       = k;
        b.push_value = v;
        queued_cmds.push_back(b);
        total_items++;
    endtask

    // Idle time before the next command beat. Mostly none or a few cycles,
    // occasionally a long hole; now and then a burst with no idling at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (roll < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one command to the mirror and return the result it should give.
    // Push into empty always lands in slot 0 with both pointers reset; a pop
    // that empties the deque sends both pointers back to 0 as well.
    function automatic t_out_beat apply_deque_op(t_in_beat c);
        t_out_beat r;
        r.pop_value = '0;
        r.status    = STAT_DONE;
        case (c.kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                n_push++;
                if (mirror_count >= DQ_DEPTH) begin
                    r.status = STAT_FULL;           // refused, nothing moves
                    n_full++;
                end else begin
                    if (mirror_count == 0) begin
                        mirror_head     = 0;
                        mirror_tail     = 0;
                        mirror_words[0] = c.push_value;
                    end else if (c.kind == KIND_PUSH_FRONT) begin
                        mirror_head = (mirror_head == 0) ? DQ_DEPTH - 1 : mirror_head - 1;
                        mirror_words[mirror_head] = c.push_value;
                    end else begin
                        mirror_tail = (mirror_tail == DQ_DEPTH - 1) ? 0 : mirror_tail + 1;
                        mirror_words[mirror_tail] = c.push_value;
                    end
                    mirror_count++;
                end
            end
            default: begin
                n_pop++;
                if (c.kind == KIND_POP_REAR) n_pop_rear++;
                if (mirror_count == 0) begin
                    r.status    = STAT_EMPTY;       // refused, reads back -1
                    r.pop_value = -1;
                    n_empty++;
                end else begin
                    if (c.kind == KIND_POP_FRONT) begin
                        r.pop_value = mirror_words[mirror_head];
                        mirror_head = (mirror_head == DQ_DEPTH - 1) ? 0 : mirror_head + 1;
                    end else begin
                        r.pop_value = mirror_words[mirror_tail];
                        mirror_tail = (mirror_tail == 0) ? DQ_DEPTH - 1 : mirror_tail - 1;
                    end
                    mirror_count--;
                    if (mirror_count == 0) begin
                        mirror_head = 0;
                        mirror_tail = 0;
                    end
                end
            end
        endcase
        // field is OCC_W bits wide, so larger depths would wrap here
        r.occupancy = mirror_count[OCC_W-1:0];
        return r;
    endfunction

    // Driver: a beat is taken at an edge where start is high and busy low.
    // Start stays up while busy holds the beat off; after each taken beat a
    // fresh gap is drawn. One nonblocking write per signal per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                void'(queued_cmds.pop_front());
                gap_left = pick_gap();
            end
            if (start && busy) begin
                // beat held, keep it on the port
            end else if (gap_left > 0 || queued_cmds.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_cmd <= queued_cmds[0];
            end
        end
    end

    // Monitor: check any strobed result first, then predict the command beat
    // taken at this same edge, so a result can never match its own command.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_strobe) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: value %0d status %0d occ %0d",
                             $time, o_result.pop_value, o_result.status, o_result.occupancy);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.pop_value !== want.pop_value) begin
                        fail_count++;
                        $display("%0t: pop_value expected %0d, got %0d",
                                 $time, want.pop_value, o_result.pop_value);
                    end
                    if (o_result.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_result.status);
                    end
                    if (o_result.occupancy !== want.occupancy) begin
                        fail_count++;
                        $display("%0t: occupancy expected %0d, got %0d",
                                 $time, want.occupancy, o_result.occupancy);
                    end
                end
            end
            if (start && !busy) begin
                pending_results.push_back(apply_deque_op(i_cmd));
                cmds_taken++;
            end
        end
    end

    // Watchdog: any beat in either direction restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("[circular_deque] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase_left;
        int push_pct;
        bit is_push;
        bit at_front;
        t_kind k;
        logic [WORD_W-1:0] w;

        // --- directed beats ---
        // pops on an empty deque are refused
        add_cmd(KIND_POP_FRONT, 32'h1234_5678);
        add_cmd(KIND_POP_REAR,  32'hFFFF_FFFF);
        // push into empty from either end lands in slot 0
        add_cmd(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        add_cmd(KIND_POP_REAR,   32'h0);
        add_cmd(KIND_PUSH_REAR,  32'h8000_0000);
        add_cmd(KIND_POP_FRONT,  32'h0);
        // fill from both ends so the head wraps below zero
        add_cmd(KIND_PUSH_FRONT, 32'h0000_0000);
        add_cmd(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        add_cmd(KIND_PUSH_REAR,  32'h5555_5555);
        add_cmd(KIND_PUSH_FRONT, 32'hAAAA_AAAA);
        add_cmd(KIND_PUSH_REAR,  32'h7FFF_FFFF);
        add_cmd(KIND_PUSH_FRONT, 32'h8000_0000);
        add_cmd(KIND_PUSH_REAR,  32'h0000_0001);
        add_cmd(KIND_PUSH_REAR,  32'hFFFF_FFFE);
        // full: both pushes refused
        add_cmd(KIND_PUSH_REAR,  32'hDEAD_BEEF);
        add_cmd(KIND_PUSH_FRONT, 32'h0BAD_F00D);
        // drain from alternate ends, the pop that empties it resets the pointers
        for (int i = 0; i < DQ_DEPTH; i++)
            add_cmd((i % 2) ? KIND_POP_REAR : KIND_POP_FRONT, 32'h0);
        add_cmd(KIND_POP_REAR, 32'h0);

        // --- random beats ---
        // Phases lean towards filling, draining or neither, so the deque
        // swings between empty and full many times with random content.
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(8, 40);
            end
            phase_left--;
            is_push  = ($urandom_range(0, 99) < push_pct);
            at_front = $urandom_range(0, 1);
            if (is_push) k = at_front ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
            else         k = at_front ? KIND_POP_FRONT  : KIND_POP_REAR;
            w = $urandom;
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0:       w = 32'h7FFF_FFFF;
                    1:       w = 32'h8000_0000;
                    2:       w = 32'h0000_0000;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
            add_cmd(k, w);
        end

        // synchronous reset, held from time zero, released at an edge
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every command to be taken and every result to come back,
        // then give the rear-pop path time to show any stray result
        while (cmds_taken < total_items || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Ran %0d commands (%0d results): %0d pushes, %0d pops, %0d of them at the rear.",
                 cmds_taken, results_seen, n_push, n_pop, n_pop_rear);
        $display("Refused pushes on a full deque: %0d, refused pops on an empty one: %0d.",
                 n_full, n_empty);
        if (fail_count == 0) begin
            $display("[circular_deque] OK");
        end else begin
            $display("[circular_deque] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/cdq_pkg.sv
sv/cdq_cell.sv
sv/cdq_ctrl.sv
sv/circular_deque.sv
sv/cdq_checker.sv
sim/circular_deque_tb.sv
